// ----- rtl/core/sspq_pkg.sv -----
// ----------------------------------------------------------------------------
// sspq_pkg
// Shared types and codes for the stable sorted priority queue.
// ----------------------------------------------------------------------------
`default_nettype none

package sspq_pkg;

   localparam int TAG_W  = 16;
   localparam int PRIO_W = 16;

   typedef enum logic {
      OP_INSERT = 1'b0,
      OP_REMOVE = 1'b1
   } op_type;

   typedef enum logic [1:0] {
      ST_OK    = 2'd0,
      ST_EMPTY = 2'd1,
      ST_FULL  = 2'd2
   } status_type;

   typedef struct packed {
      logic [TAG_W-1:0]  tag;
      logic [PRIO_W-1:0] prio;
   } entry_type;

   typedef struct packed {
      logic      insert;
      logic      remove;
      entry_type item;
   } cell_ctl_type;

endpackage

`default_nettype wire

// ----- rtl/core/sspq_if.sv -----
// ----------------------------------------------------------------------------
// sspq request and response interfaces
// Valid/ready channels carrying one queue command word and one result word.
// ----------------------------------------------------------------------------
`default_nettype none

interface sspq_req_if;
   logic        valid;
   logic        ready;
   logic        op;
   logic [15:0] tag;
   logic [15:0] priority_req;

   modport source (output valid, output op, output tag, output priority_req, input ready);
   modport sink   (input valid, input op, input tag, input priority_req, output ready);
endinterface

interface sspq_rsp_if;
   logic        valid;
   logic        ready;
   logic [15:0] out_tag;
   logic [15:0] out_priority;
   logic [1:0]  status;
   logic        is_empty;

   modport source (output valid, output out_tag, output out_priority, output status,
                   output is_empty, input ready);
   modport sink   (input valid, input out_tag, input out_priority, input status,
                   input is_empty, output ready);
endinterface

`default_nettype wire

// ----- rtl/core/stable_sorted_priority_queue.sv -----
// Result: registered in the cycle after its request word is accepted.
// Throughput: one word per cycle while results are taken; all slots update at once.
// A held result does not block the next request once the sink takes it.
// Reset: synchronous, clears the entry count and the result valid; slot data is not reset.
// ----------------------------------------------------------------------------
// stable_sorted_priority_queue
// Bounded min priority queue, stable for equal priorities, built as a row of cells.
// ----------------------------------------------------------------------------
`default_nettype none

module stable_sorted_priority_queue #(
   parameter int CAPACITY = 16
) (
   input wire          clock,
   input wire          reset,
   sspq_req_if.sink    req,
   sspq_rsp_if.source  rsp
);
   import sspq_pkg::*;

   localparam int CW = $clog2(CAPACITY + 1);

   logic [CW-1:0] count_ff;
   logic [CW-1:0] count_in;
   logic          rsp_valid_ff;
   logic          rsp_valid_in;
   logic [15:0]   rsp_tag_ff, rsp_tag_in;
   logic [15:0]   rsp_prio_ff, rsp_prio_in;
   status_type    rsp_status_ff, rsp_status_in;
   logic          rsp_empty_ff, rsp_empty_in;

   logic          accept;
   logic          is_full;
   logic          is_empty_now;
   cell_ctl_type  ctl;
   entry_type     slot_data [CAPACITY];
   logic          slot_keep [CAPACITY];

   assign req.ready    = !rsp_valid_ff || rsp.ready;
   assign accept       = req.valid && req.ready;
   assign is_full      = (count_ff == CW'(CAPACITY));
   assign is_empty_now = (count_ff == '0);

   always_comb begin
      ctl.insert    = accept && (op_type'(req.op) == OP_INSERT) && !is_full;
      ctl.remove    = accept && (op_type'(req.op) == OP_REMOVE) && !is_empty_now;
      ctl.item.tag  = req.tag;
      ctl.item.prio = req.priority_req;
   end

   for (genvar i = 0; i < CAPACITY; i++) begin : g_slot
      entry_type prev_d;
      entry_type next_d;
      logic      prev_k;
      if (i == 0) begin : g_head
         assign prev_d = '0;
         assign prev_k = 1'b1;
      end else begin : g_body
         assign prev_d = slot_data[i-1];
         assign prev_k = slot_keep[i-1];
      end
      if (i == CAPACITY - 1) begin : g_tail
         assign next_d = '0;
      end else begin : g_mid
         assign next_d = slot_data[i+1];
      end
      sspq_cell u_slot (
         .clock     (clock),
         .ctl       (ctl),
         .occupied  (count_ff > CW'(i)),
         .prev_keep (prev_k),
         .prev_data (prev_d),
         .next_data (next_d),
         .data      (slot_data[i]),
         .keep      (slot_keep[i])
      );
   end

   always_comb begin
      count_in = count_ff;
      if (ctl.insert) begin
         count_in = count_ff + CW'(1);
      end else if (ctl.remove) begin
         count_in = count_ff - CW'(1);
      end
   end

   always_comb begin
      rsp_valid_in  = rsp_valid_ff;
      rsp_tag_in    = rsp_tag_ff;
      rsp_prio_in   = rsp_prio_ff;
      rsp_status_in = rsp_status_ff;
      rsp_empty_in  = rsp_empty_ff;
      if (rsp_valid_ff && rsp.ready) begin
         rsp_valid_in = 1'b0;
      end
      if (accept) begin
         rsp_valid_in  = 1'b1;
         rsp_tag_in    = ctl.remove ? slot_data[0].tag : 16'd0;
         rsp_prio_in   = ctl.remove ? slot_data[0].prio : 16'd0;
         rsp_empty_in  = (count_in == '0);
         rsp_status_in = ST_OK;
         if (op_type'(req.op) == OP_INSERT && is_full) begin
            rsp_status_in = ST_FULL;
         end else if (op_type'(req.op) == OP_REMOVE && is_empty_now) begin
            rsp_status_in = ST_EMPTY;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      rsp_tag_ff    <= rsp_tag_in;
      rsp_prio_ff   <= rsp_prio_in;
      rsp_status_ff <= rsp_status_in;
      rsp_empty_ff  <= rsp_empty_in;
   end

   assign rsp.valid        = rsp_valid_ff;
   assign rsp.out_tag      = rsp_tag_ff;
   assign rsp.out_priority = rsp_prio_ff;
   assign rsp.status       = rsp_status_ff;
   assign rsp.is_empty     = rsp_empty_ff;

`ifndef SYNTH
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CW'(CAPACITY))
      else $error("entry count beyond capacity");

   a_empty_remove: assert property (@(posedge clock) disable iff (reset)
      accept && req.op == OP_REMOVE && is_empty_now |=> rsp_valid_ff && rsp_status_ff == ST_EMPTY)
      else $error("remove on empty queue not flagged");

   a_full_hold: assert property (@(posedge clock) disable iff (reset)
      accept && req.op == OP_INSERT && is_full |=> $stable(count_ff))
      else $error("insert on full queue changed the count");

   a_empty_flag: assert property (@(posedge clock) disable iff (reset)
      accept |=> rsp_empty_ff == (count_ff == '0))
      else $error("empty flag disagrees with entry count");
`endif

endmodule

`default_nettype wire

// ----- rtl/core/sspq_cell.sv -----
// ----------------------------------------------------------------------------
// sspq_cell
// One slot of the sorted row: holds, takes the new entry, or shifts.
// ----------------------------------------------------------------------------
`default_nettype none

module sspq_cell (
   input  wire                     clock,
   input  sspq_pkg::cell_ctl_type  ctl,
   input  wire                     occupied,
   input  wire                     prev_keep,
   input  sspq_pkg::entry_type     prev_data,
   input  sspq_pkg::entry_type     next_data,
   output sspq_pkg::entry_type     data,
   output logic                    keep
);
   import sspq_pkg::*;

   entry_type data_ff;
   entry_type data_in;

   assign keep = occupied && (data_ff.prio <= ctl.item.prio);
   assign data = data_ff;

   always_comb begin
      data_in = data_ff;
      if (ctl.insert) begin
         if (keep) begin
            data_in = data_ff;
         end else if (prev_keep) begin
            data_in = ctl.item;
         end else begin
            data_in = prev_data;
         end
      end else if (ctl.remove) begin
         data_in = next_data;
      end
   end

   always_ff @(posedge clock) begin
      data_ff <= data_in;
   end

endmodule

`default_nettype wire

// ----- dv/stable_sorted_priority_queue_test.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// stable_sorted_priority_queue_test
// Drives insert and remove words into the priority queue and checks every
// result word against a scoreboard queue that tracks the sorted entries,
// including remove on empty, insert on full and tie ordering.
// ----------------------------------------------------------------------------

module stable_sorted_priority_queue_test;
   import sspq_pkg::*;

   localparam int CAPACITY    = 16;
   localparam int CYCLE_LIMIT = 200000;
   localparam int DRAIN_WAIT  = 5;

   typedef struct {
      op_type      op;
      logic [15:0] tag;
      logic [15:0] prio;
   } command_type;

   typedef struct {
      logic [15:0] tag;
      logic [15:0] prio;
      status_type  status;
      logic        is_empty;
   } result_type;

   logic clock;
   logic reset;

   sspq_req_if req_bus ();
   sspq_rsp_if rsp_bus ();

   stable_sorted_priority_queue #(.CAPACITY(CAPACITY)) uut (
      .clock (clock),
      .reset (reset),
      .req   (req_bus.sink),
      .rsp   (rsp_bus.source)
   );

   command_type pending_words[$];
   result_type  expected_results[$];
   entry_type   held_entries[$];
   int          send_idle_pct;
   int          recv_idle_pct;
   int          fail_count;
   int          cycle_count;
   bit          word_taken;

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   function automatic result_type apply_queue_word(op_type op, logic [15:0] tag,
                                                   logic [15:0] prio);
      result_type res;
      entry_type  fresh;
      int         pos;
      res.tag    = '0;
      res.prio   = '0;
      res.status = ST_OK;
      if (op == OP_INSERT) begin
         if (held_entries.size() >= CAPACITY) begin
            res.status = ST_FULL;
         end else begin
            pos = 0;
            while (pos < held_entries.size() && held_entries[pos].prio <= prio)
               pos++;
            fresh.tag  = tag;
            fresh.prio = prio;
            held_entries.insert(pos, fresh);
         end
      end else begin
         if (held_entries.size() == 0) begin
            res.status = ST_EMPTY;
         end else begin
            fresh    = held_entries.pop_front();
            res.tag  = fresh.tag;
            res.prio = fresh.prio;
         end
      end
      res.is_empty = (held_entries.size() == 0);
      return res;
   endfunction

   task automatic push_word(op_type op, logic [15:0] tag, logic [15:0] prio);
      command_type w;
      w.op   = op;
      w.tag  = tag;
      w.prio = prio;
      pending_words.push_back(w);
   endtask

   function automatic logic [15:0] pick_priority(int mode);
      logic [15:0] p;
      case (mode)
         0: begin
            p = 16'($urandom_range(3));
         end
         1: begin
            case ($urandom_range(3))
               0: p = 16'h0000;
               1: p = 16'hFFFF;
               2: p = 16'h7FFF;
               default: p = 16'h8000;
            endcase
         end
         default: begin
            p = 16'($urandom_range(16'hFFFF));
         end
      endcase
      return p;
   endfunction

   task automatic add_random_words(int total);
      int made;
      int run_len;
      int ins_pct;
      int prio_mode;
      int k;
      made = 0;
      while (made < total) begin
         run_len   = $urandom_range(40, 4);
         prio_mode = $urandom_range(3);
         case ($urandom_range(3))
            0: ins_pct = 85;
            1: ins_pct = 15;
            2: ins_pct = 50;
            default: ins_pct = 60;
         endcase
         for (k = 0; k < run_len && made < total; k++) begin
            push_word(($urandom_range(99) < ins_pct) ? OP_INSERT : OP_REMOVE,
                      16'($urandom_range(16'hFFFF)), pick_priority(prio_mode));
            made++;
         end
      end
   endtask

   task automatic drain;
      while (pending_words.size() != 0 || (req_bus.valid && !word_taken) ||
             expected_results.size() != 0)
         @(negedge clock);
   endtask

   // drive request words and result ready
   always @(negedge clock) begin
      command_type next_word;
      if (reset) begin
         req_bus.valid <= 1'b0;
         rsp_bus.ready <= 1'b0;
      end else begin
         rsp_bus.ready <= ($urandom_range(99) >= recv_idle_pct);
         if (!req_bus.valid || word_taken) begin
            if (pending_words.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
               next_word = pending_words.pop_front();
               req_bus.valid        <= 1'b1;
               req_bus.op           <= next_word.op;
               req_bus.tag          <= next_word.tag;
               req_bus.priority_req <= next_word.prio;
            end else begin
               req_bus.valid <= 1'b0;
            end
         end
      end
   end

   // predict on accepted requests, check accepted results
   always @(posedge clock) begin
      result_type exp_word;
      word_taken = 1'b0;
      if (!reset) begin
         if (req_bus.valid && req_bus.ready) begin
            expected_results.push_back(apply_queue_word(op_type'(req_bus.op),
                                                        req_bus.tag,
                                                        req_bus.priority_req));
            word_taken = 1'b1;
         end
         if (rsp_bus.valid && rsp_bus.ready) begin
            if (expected_results.size() == 0) begin
               fail_count++;
               if (fail_count <= 10)
                  $display("%0t unexpected result word: tag %h prio %h status %0d empty %b",
                           $realtime, rsp_bus.out_tag, rsp_bus.out_priority,
                           rsp_bus.status, rsp_bus.is_empty);
            end else begin
               exp_word = expected_results.pop_front();
               if (rsp_bus.out_tag !== exp_word.tag || rsp_bus.out_priority !== exp_word.prio ||
                   rsp_bus.status !== exp_word.status ||
                   rsp_bus.is_empty !== exp_word.is_empty) begin
                  fail_count++;
                  if (fail_count <= 10)
                     $display({"%0t mismatch: exp tag %h prio %h status %0d empty %b, ",
                               "got tag %h prio %h status %0d empty %b"},
                              $realtime, exp_word.tag, exp_word.prio, exp_word.status,
                              exp_word.is_empty, rsp_bus.out_tag, rsp_bus.out_priority,
                              rsp_bus.status, rsp_bus.is_empty);
               end
            end
         end
      end
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("RESULT: ERROR");
         $finish;
      end
   end

   initial begin
      int i;
      reset                = 1'b1;
      req_bus.valid        = 1'b0;
      req_bus.op           = OP_INSERT;
      req_bus.tag          = '0;
      req_bus.priority_req = '0;
      rsp_bus.ready        = 1'b0;
      send_idle_pct        = 33;
      recv_idle_pct        = 61;
      fail_count           = 0;
      cycle_count          = 0;
      word_taken           = 1'b0;

      // empty remove, extremes, ties, fill to full, full insert, stable removes
      push_word(OP_REMOVE, 16'hFFFF, 16'hFFFF);
      push_word(OP_INSERT, 16'hFFFF, 16'hFFFF);
      push_word(OP_INSERT, 16'h0000, 16'h0000);
      push_word(OP_INSERT, 16'h0001, 16'h0005);
      push_word(OP_INSERT, 16'h0002, 16'h0005);
      push_word(OP_INSERT, 16'h0003, 16'h0005);
      push_word(OP_INSERT, 16'h0004, 16'h0000);
      push_word(OP_INSERT, 16'h0005, 16'hFFFF);
      for (i = 6; i < CAPACITY; i++)
         push_word(OP_INSERT, 16'(i), 16'(16'h0100 * i));
      push_word(OP_INSERT, 16'hAAAA, 16'h0000);
      push_word(OP_REMOVE, 16'h5555, 16'h5555);
      push_word(OP_REMOVE, 16'h0000, 16'h0000);
      push_word(OP_REMOVE, 16'hFFFF, 16'h0000);

      repeat (8) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      add_random_words(410);
      drain();

      send_idle_pct = 61;
      recv_idle_pct = 33;
      add_random_words(420);
      drain();

      send_idle_pct = 0;
      recv_idle_pct = 0;
      add_random_words(400);
      drain();

      repeat (DRAIN_WAIT) @(posedge clock);
      if (fail_count == 0) begin
         $display("RESULT: OK");
      end else begin
         $display("RESULT: ERROR");
      end
      $finish;
   end

endmodule
